### design/lapl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapl_pkg
// Shared types, constants and linearization table of the actuator position loop.
// ----------------------------------------------------------------------------
package lapl_pkg;

  localparam int TABLE_POINTS = 7;
  localparam int SAMPLE_BITS  = 12;

  localparam int SEG_W     = $clog2(TABLE_POINTS + 1);
  localparam int IDX_W     = $clog2(TABLE_POINTS);
  localparam int DVD_W     = SAMPLE_BITS + 3;
  localparam int DVS_W     = 8;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic [SAMPLE_BITS-1:0] SEG_POINT [TABLE_POINTS] =
    '{5, 130, 969, 2070, 3190, 3845, 3965};
  localparam logic [DVS_W-1:0] SEG_FACTOR [TABLE_POINTS] =
    '{15, 120, 137, 140, 93, 15, 10};

  localparam int LIN_MUL     = 7;
  localparam int LIN_DIV     = 5;
  localparam int SEG_SPAN    = 7;
  localparam int SEG_OFFSET  = 3;
  localparam int SP_MIN      = 2;
  localparam int SP_MAX      = 55;
  localparam int SAT_ERR     = 5;
  localparam int POS_MAX     = 127;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] CFG_VOLT_NOM  = 3'd0;
  localparam logic [2:0] CFG_VOLT_MAR  = 3'd1;
  localparam logic [2:0] CFG_CURR_NOM  = 3'd2;
  localparam logic [2:0] CFG_CURR_MAR  = 3'd3;
  localparam logic [2:0] CFG_HOME_POS  = 3'd4;
  localparam logic [2:0] CFG_HOME_DWL  = 3'd5;
  localparam logic [2:0] CFG_GAIN      = 3'd6;
  localparam logic [2:0] CFG_DRIVE_MAX = 3'd7;

  localparam logic [2:0] FAULT_NONE      = 3'd0;
  localparam logic [2:0] FAULT_VOLT_LOW  = 3'd1;
  localparam logic [2:0] FAULT_VOLT_HIGH = 3'd2;
  localparam logic [2:0] FAULT_CURR_LOW  = 3'd3;
  localparam logic [2:0] FAULT_CURR_HIGH = 3'd4;

  typedef enum logic [1:0] {
    REQ_SETPOINT = 2'd0,
    REQ_SUPPLY   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_NONE     = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] volt_nom;
    logic [11:0] volt_mar;
    logic [11:0] curr_nom;
    logic [11:0] curr_mar;
    logic [5:0]  home_pos;
    logic [5:0]  home_dwell;
    logic [11:0] drive_gain;
    logic [15:0] drive_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    volt_nom:   12'd2420,
    volt_mar:   12'd800,
    curr_nom:   12'd2420,
    curr_mar:   12'd360,
    home_pos:   6'd30,
    home_dwell: 6'd25,
    drive_gain: 12'd200,
    drive_max:  16'd1000
  };

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  setpoint_byte;
    logic [11:0] voltage_sample;
    logic [11:0] current_sample;
    logic [11:0] position_sample;
  } req_t;

  typedef struct packed {
    logic [6:0]  position_mm;
    logic [2:0]  fault_code;
    logic        move_forward;
    logic [15:0] pulse_width;
    logic [5:0]  active_setpoint;
  } res_t;

  typedef struct packed {
    logic capture;
    logic setpoint;
    logic supply;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      div_done;
    logic      out_free;
  } sts_t;

endpackage

### design/lapl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapl_req_if
// Request channel: request kind and the sample fields, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lapl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  setpoint_byte;
  logic [11:0] voltage_sample;
  logic [11:0] current_sample;
  logic [11:0] position_sample;

  modport source (
    output valid, req_type, setpoint_byte, voltage_sample, current_sample,
           position_sample,
    input  ready
  );
  modport sink (
    input  valid, req_type, setpoint_byte, voltage_sample, current_sample,
           position_sample,
    output ready
  );
endinterface

### design/lapl_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapl_res_if
// Result channel: position, fault, direction, pulse and setpoint per tick.
// ----------------------------------------------------------------------------
interface lapl_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  position_mm;
  logic [2:0]  fault_code;
  logic        move_forward;
  logic [15:0] pulse_width;
  logic [5:0]  active_setpoint;

  modport source (
    output valid, position_mm, fault_code, move_forward, pulse_width,
           active_setpoint,
    input  ready
  );
  modport sink (
    input  valid, position_mm, fault_code, move_forward, pulse_width,
           active_setpoint,
    output ready
  );
endinterface

### design/lapl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapl_cfg
// APB-style configuration register file with read-back.
// ----------------------------------------------------------------------------
module lapl_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lapl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lapl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lapl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output lapl_pkg::cfg_t                  cfg
);
  import lapl_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        CFG_VOLT_NOM:  cfg_nxt.volt_nom   = pwdata[11:0];
        CFG_VOLT_MAR:  cfg_nxt.volt_mar   = pwdata[11:0];
        CFG_CURR_NOM:  cfg_nxt.curr_nom   = pwdata[11:0];
        CFG_CURR_MAR:  cfg_nxt.curr_mar   = pwdata[11:0];
        CFG_HOME_POS:  cfg_nxt.home_pos   = pwdata[5:0];
        CFG_HOME_DWL:  cfg_nxt.home_dwell = pwdata[5:0];
        CFG_GAIN:      cfg_nxt.drive_gain = pwdata[11:0];
        CFG_DRIVE_MAX: cfg_nxt.drive_max  = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_VOLT_NOM:  prdata = CFG_DATA_W'(cfg_r.volt_nom);
      CFG_VOLT_MAR:  prdata = CFG_DATA_W'(cfg_r.volt_mar);
      CFG_CURR_NOM:  prdata = CFG_DATA_W'(cfg_r.curr_nom);
      CFG_CURR_MAR:  prdata = CFG_DATA_W'(cfg_r.curr_mar);
      CFG_HOME_POS:  prdata = CFG_DATA_W'(cfg_r.home_pos);
      CFG_HOME_DWL:  prdata = CFG_DATA_W'(cfg_r.home_dwell);
      CFG_GAIN:      prdata = CFG_DATA_W'(cfg_r.drive_gain);
      CFG_DRIVE_MAX: prdata = CFG_DATA_W'(cfg_r.drive_max);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/lapl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapl_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lapl_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lapl_pkg::DVD_W-1:0] dividend,
  input  logic [lapl_pkg::DVS_W-1:0] divisor,
  output logic [lapl_pkg::DVD_W-1:0] quotient,
  output logic                       done
);
  import lapl_pkg::*;

  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVS_W:0]       shifted;
  logic [DVS_W+1:0]     diff;

  assign shifted  = {rem_r, quo_r[DVD_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs_r};
  assign quotient = quo_r;
  assign done     = done_r;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DVS_W+1]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");

endmodule

### design/lapl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapl_dp
// Datapath: request capture, setpoint and fault state, linearization with a
// serial divider, drive pulse, dwell counter and output register.
// ----------------------------------------------------------------------------
module lapl_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  lapl_pkg::cfg_t cfg,
  input  lapl_pkg::req_t req,
  input  lapl_pkg::cmd_t cmd,
  input  logic           out_ready,
  output lapl_pkg::sts_t sts,
  output lapl_pkg::res_t res,
  output logic           out_valid
);
  import lapl_pkg::*;

  req_kind_t              kind_r;
  logic [7:0]             spb_r;
  logic [11:0]            volt_r;
  logic [11:0]            curr_r;
  logic [SAMPLE_BITS-1:0] samp_r;

  logic [5:0]       target_r, target_nxt;
  logic [2:0]       fault_r, fault_nxt;
  logic [5:0]       dwell_r, dwell_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r;

  logic [SEG_W-1:0] seg;
  logic [SEG_W-1:0] seg_r;
  logic [IDX_W-1:0] seg_idx;
  logic             run;
  logic             fzero_r;
  logic [DVD_W-1:0] dividend;
  logic [DVS_W-1:0] divisor;
  logic [DVD_W-1:0] quo;
  logic             div_done;
  logic [DVD_W-1:0] q_eff;
  logic [DVD_W:0]   mm_sum;
  logic [6:0]       pos_r;

  logic [7:0]  err;
  logic [7:0]  mag;
  logic [14:0] prod;
  logic [15:0] pulse;
  logic [6:0]  dwell_inc;
  logic [12:0] v_lo_sum, v_hi_lim, c_lo_sum, c_hi_lim;

  // segment search over the table points
  always_comb begin
    run = 1'b1;
    seg = '0;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      if (run && samp_r >= SEG_POINT[i]) begin
        seg = seg + SEG_W'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  assign seg_idx  = IDX_W'(seg - SEG_W'(1));
  assign dividend = (seg == '0) ? (DVD_W'(samp_r) * DVD_W'(LIN_MUL))
                                : DVD_W'(samp_r - SEG_POINT[seg_idx]);
  assign divisor  = (seg == '0) ? DVS_W'(LIN_DIV) : SEG_FACTOR[seg_idx];

  lapl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quo),
    .done     (div_done)
  );

  assign q_eff  = fzero_r ? '0 : quo;
  assign mm_sum = (seg_r == '0) ? {1'b0, q_eff}
                : ({1'b0, q_eff} + (DVD_W+1)'(seg_r) * (DVD_W+1)'(SEG_SPAN)
                   + (DVD_W+1)'(SEG_OFFSET));

  // drive pulse
  assign err   = {2'b00, target_r} - {1'b0, pos_r};
  assign mag   = err[7] ? (8'd0 - err) : err;
  assign prod  = cfg.drive_gain * mag[2:0];
  assign pulse = (fault_r != FAULT_NONE) ? 16'd0
               : (mag >= 8'(SAT_ERR)) ? cfg.drive_max : {1'b0, prod};

  // supply windows
  assign v_lo_sum  = {1'b0, volt_r} + {1'b0, cfg.volt_mar};
  assign v_hi_lim  = {1'b0, cfg.volt_nom} + {1'b0, cfg.volt_mar};
  assign c_lo_sum  = {1'b0, curr_r} + {1'b0, cfg.curr_mar};
  assign c_hi_lim  = {1'b0, cfg.curr_nom} + {1'b0, cfg.curr_mar};
  assign dwell_inc = {1'b0, dwell_r} + 7'd1;

  always_comb begin
    target_nxt = target_r;
    fault_nxt  = fault_r;
    dwell_nxt  = dwell_r;
    if (cmd.setpoint) begin
      if (spb_r > 8'(SP_MAX)) begin
        target_nxt = 6'(SP_MAX);
      end else if (spb_r < 8'(SP_MIN)) begin
        target_nxt = 6'(SP_MIN);
      end else begin
        target_nxt = spb_r[5:0];
      end
    end
    if (cmd.supply) begin
      priority if (v_lo_sum < {1'b0, cfg.volt_nom}) begin
        fault_nxt = FAULT_VOLT_LOW;
      end else if ({1'b0, volt_r} > v_hi_lim) begin
        fault_nxt = FAULT_VOLT_HIGH;
      end else if (c_lo_sum < {1'b0, cfg.curr_nom}) begin
        fault_nxt = FAULT_CURR_LOW;
      end else if ({1'b0, curr_r} > c_hi_lim) begin
        fault_nxt = FAULT_CURR_HIGH;
      end else begin
        fault_nxt = FAULT_NONE;
      end
    end
    if (cmd.commit && mag <= 8'd1 && target_r != cfg.home_pos) begin
      if (dwell_inc >= {1'b0, cfg.home_dwell} || dwell_inc[6]) begin
        target_nxt = cfg.home_pos;
        dwell_nxt  = '0;
      end else begin
        dwell_nxt = dwell_inc[5:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= CFG_RESET.home_pos;
      fault_r     <= FAULT_NONE;
      dwell_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      target_r    <= target_nxt;
      fault_r     <= fault_nxt;
      dwell_r     <= dwell_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= req_kind_t'(req.req_type);
      spb_r  <= req.setpoint_byte;
      volt_r <= req.voltage_sample;
      curr_r <= req.current_sample;
      samp_r <= req.position_sample[SAMPLE_BITS-1:0];
    end
    if (cmd.div_start) begin
      seg_r   <= seg;
      fzero_r <= (seg != '0) && (divisor == '0);
    end
    if (div_done) begin
      pos_r <= (mm_sum > (DVD_W+1)'(POS_MAX)) ? 7'(POS_MAX) : mm_sum[6:0];
    end
    if (cmd.commit) begin
      res_r.position_mm     <= pos_r;
      res_r.fault_code      <= fault_r;
      res_r.move_forward    <= !err[7];
      res_r.pulse_width     <= pulse;
      res_r.active_setpoint <= target_nxt;
    end
  end

  assign res          = res_r;
  assign out_valid    = out_valid_r;
  assign sts.kind     = kind_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

### design/lapl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapl_ctrl
// Controller: accepts a request, dispatches it by kind, waits on the divider
// and commits the tick result when the output register is free.
// ----------------------------------------------------------------------------
module lapl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lapl_pkg::sts_t sts,
  output lapl_pkg::cmd_t cmd
);
  import lapl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.kind)
          REQ_SETPOINT: begin
            cmd.setpoint = 1'b1;
            state_nxt    = ST_IDLE;
          end
          REQ_SUPPLY: begin
            cmd.supply = 1'b1;
            state_nxt  = ST_IDLE;
          end
          REQ_TICK: begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
          REQ_NONE: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted request not dispatched");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result committed over a pending one");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && !sts.div_done |=> state_r == ST_DIV)
    else $error("left divide wait early");

  a_start_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.kind == REQ_TICK)
    else $error("divider started for a non-tick request");

endmodule

### design/linear_actuator_position_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_actuator_position_loop
// Actuator position loop: setpoint clamp, supply fault windows, piecewise-
// linear position, proportional drive pulse and home return after dwell.
//
//   channel  | direction | handshake             | carries
//   in_req   | in        | valid/ready           | kind, setpoint, supply, position
//   out_res  | out       | valid/ready           | position, fault, dir, pulse, sp
//   cfg      | in        | APB write, pready = 1 | eight registers at 4*i
//
// A setpoint or supply request is accepted, then executed.
// A control tick runs through accept, dispatch, 15 divide steps of the serial
// divider of the linearization, position latch and commit.
// A result waiting in the output register stalls only the commit of the next tick.
// Reset (rst_n low, synchronous) restores the config registers, target 30, no fault, dwell 0.
// ----------------------------------------------------------------------------
module linear_actuator_position_loop (
  input  logic                            clk,
  input  logic                            rst_n,
  lapl_req_if.sink                        in_req,
  lapl_res_if.source                      out_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lapl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lapl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lapl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lapl_pkg::*;

  cfg_t cfg;
  req_t req;
  res_t res;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  assign req.req_type        = in_req.req_type;
  assign req.setpoint_byte   = in_req.setpoint_byte;
  assign req.voltage_sample  = in_req.voltage_sample;
  assign req.current_sample  = in_req.current_sample;
  assign req.position_sample = in_req.position_sample;
  assign in_req.ready        = in_ready;

  assign out_res.valid           = out_valid;
  assign out_res.position_mm     = res.position_mm;
  assign out_res.fault_code      = res.fault_code;
  assign out_res.move_forward    = res.move_forward;
  assign out_res.pulse_width     = res.pulse_width;
  assign out_res.active_setpoint = res.active_setpoint;

  lapl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lapl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lapl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req       (req),
    .cmd       (cmd),
    .out_ready (out_res.ready),
    .sts       (sts),
    .res       (res),
    .out_valid (out_valid)
  );

endmodule
